/* sv/sabc_pkg.sv */
// Shared types and constants for the sprite alpha-blend compositor.
// Used by the front end, the command queue, the back end and the top level.
`timescale 1ns / 1ps

package sabc_pkg;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_BLEND = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [1:0] ST_STORED  = 2'd0;
  localparam logic [1:0] ST_CLIPPED = 2'd1;
  localparam logic [1:0] ST_SKIPPED = 2'd2;
  localparam logic [1:0] ST_READ    = 2'd3;

  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ROW_OFFSET = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_COL_OFFSET = 2'd1;

  localparam int unsigned OffW = 10;

  typedef enum logic [1:0] {
    K_WRITE,
    K_READ,
    K_BLEND,
    K_DONE
  } kind_e;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_FETCH,
    BS_MIX
  } back_state_e;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] row;
    logic [7:0] col;
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;
    logic [7:0] alpha;
  } in_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;
  } out_t;

  // Pixel layout: third channel in the top byte, first channel in the low byte.
  typedef struct packed {
    kind_e       kind;
    logic [1:0]  status;
    logic [23:0] pixel;
    logic [7:0]  alpha;
  } cmd_t;

endpackage

/* sv/sprite_alpha_blend_compositor.sv */
// Writes and rejected words go from the queue to the output register; a read first passes
// the framebuffer's registered read port, a blend also the registered multiply stage. The
// back end takes a write or rejected word every cycle while the output is free, but takes
// no new word during a read or blend. A two-word queue lets the input run ahead of it.
// Reset clears control state and both offsets to zero; the framebuffer is not cleared.
// Top level; depends on sabc_pkg, sabc_front, sabc_queue and sabc_back.
`timescale 1ns / 1ps

module sprite_alpha_blend_compositor #(
  parameter int unsigned FRAME_DIM  = 256,
  parameter int unsigned SPRITE_DIM = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sabc_pkg::in_t                in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output sabc_pkg::out_t               out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sabc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sabc_pkg::OffW-1:0]    cfg_data_i
);

  localparam int unsigned AW = 2 * $clog2(FRAME_DIM);

  logic           push_valid, push_stall, pop_valid, pop_ready;
  sabc_pkg::cmd_t push_cmd, pop_cmd;
  logic [AW-1:0]  push_addr, pop_addr;

  sabc_front #(
    .FRAME_DIM  (FRAME_DIM),
    .SPRITE_DIM (SPRITE_DIM)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_data_i    (in_data_i),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_valid_o (push_valid),
    .push_stall_i (push_stall),
    .push_cmd_o   (push_cmd),
    .push_addr_o  (push_addr)
  );

  sabc_queue #(
    .AW (AW)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_stall_o (push_stall),
    .push_cmd_i   (push_cmd),
    .push_addr_i  (push_addr),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd),
    .pop_addr_o   (pop_addr)
  );

  sabc_back #(
    .AW (AW)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .pop_addr_i  (pop_addr),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

/* sv/sabc_front.sv */
// Front end: offset registers, input acceptance and classification of each word.
// Depends on sabc_pkg; feeds sabc_queue.
`timescale 1ns / 1ps

module sabc_front #(
  parameter int unsigned FRAME_DIM  = 256,
  parameter int unsigned SPRITE_DIM = 64,
  localparam int unsigned RW = $clog2(FRAME_DIM),
  localparam int unsigned AW = 2 * RW
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  sabc_pkg::in_t                in_data_i,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [sabc_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [sabc_pkg::OffW-1:0]    cfg_data_i,
  output logic                         push_valid_o,
  input  logic                         push_stall_i,
  output sabc_pkg::cmd_t               push_cmd_o,
  output logic [AW-1:0]                push_addr_o
);

  localparam int unsigned CW = (RW + 2 > 11) ? RW + 2 : 11;

  logic signed [sabc_pkg::OffW-1:0] row_off_q, row_off_d;
  logic signed [sabc_pkg::OffW-1:0] col_off_q, col_off_d;

  logic        [CW-1:0] rx, cx;
  logic signed [CW-1:0] tr, tc;
  logic                 src_in_frame, dst_in_frame, in_sprite;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    row_off_d = row_off_q;
    col_off_d = col_off_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        sabc_pkg::CFG_ROW_OFFSET: row_off_d = cfg_data_i;
        sabc_pkg::CFG_COL_OFFSET: col_off_d = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_off_q <= '0;
      col_off_q <= '0;
    end else begin
      row_off_q <= row_off_d;
      col_off_q <= col_off_d;
    end
  end

  always_comb begin
    rx = CW'(in_data_i.row);
    cx = CW'(in_data_i.col);
    tr = $signed(rx) + CW'(row_off_q);
    tc = $signed(cx) + CW'(col_off_q);
    src_in_frame = (rx < CW'(FRAME_DIM)) && (cx < CW'(FRAME_DIM));
    dst_in_frame = !tr[CW-1] && !tc[CW-1] &&
                   (tr < $signed(CW'(FRAME_DIM))) && (tc < $signed(CW'(FRAME_DIM)));
    in_sprite    = (rx < CW'(SPRITE_DIM)) && (cx < CW'(SPRITE_DIM));
  end

  always_comb begin
    push_cmd_o.kind   = sabc_pkg::K_DONE;
    push_cmd_o.status = sabc_pkg::ST_SKIPPED;
    push_cmd_o.pixel  = {in_data_i.chan_third, in_data_i.chan_second, in_data_i.chan_first};
    push_cmd_o.alpha  = in_data_i.alpha;
    push_addr_o       = {rx[RW-1:0], cx[RW-1:0]};
    unique case (in_data_i.op)
      sabc_pkg::OP_WRITE: begin
        if (src_in_frame) begin
          push_cmd_o.kind = sabc_pkg::K_WRITE;
        end else begin
          push_cmd_o.status = sabc_pkg::ST_CLIPPED;
        end
      end
      sabc_pkg::OP_READ: begin
        if (src_in_frame) begin
          push_cmd_o.kind = sabc_pkg::K_READ;
        end else begin
          push_cmd_o.status = sabc_pkg::ST_CLIPPED;
        end
      end
      sabc_pkg::OP_BLEND: begin
        push_addr_o = {tr[RW-1:0], tc[RW-1:0]};
        if (in_data_i.alpha == 8'd0) begin
          push_cmd_o.status = sabc_pkg::ST_SKIPPED;
        end else if (!in_sprite || !dst_in_frame) begin
          push_cmd_o.status = sabc_pkg::ST_CLIPPED;
        end else begin
          push_cmd_o.kind = sabc_pkg::K_BLEND;
        end
      end
      default: ;
    endcase
  end

  assign push_valid_o = in_valid_i;
  assign in_stall_o   = push_stall_i;

endmodule

/* sv/sabc_queue.sv */
// Two-entry command queue between the front end and the back end.
// Depends on sabc_pkg for the command type.
`timescale 1ns / 1ps

module sabc_queue #(
  parameter int unsigned AW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_stall_o,
  input  sabc_pkg::cmd_t push_cmd_i,
  input  logic [AW-1:0]  push_addr_i,
  output logic           pop_valid_o,
  input  logic           pop_ready_i,
  output sabc_pkg::cmd_t pop_cmd_o,
  output logic [AW-1:0]  pop_addr_o
);

  sabc_pkg::cmd_t cmd_q [2];
  logic [AW-1:0]  addr_q [2];
  logic           wr_ptr_q, wr_ptr_d;
  logic           rd_ptr_q, rd_ptr_d;
  logic [1:0]     count_q, count_d;
  logic           push, pop;

  assign push_stall_o = (count_q == 2'd2);
  assign pop_valid_o  = (count_q != 2'd0);
  assign push         = push_valid_i && !push_stall_o;
  assign pop          = pop_ready_i && pop_valid_o;
  assign pop_cmd_o    = cmd_q[rd_ptr_q];
  assign pop_addr_o   = addr_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      cmd_q[wr_ptr_q]  <= push_cmd_i;
      addr_q[wr_ptr_q] <= push_addr_i;
    end
  end

endmodule

/* sv/sabc_back.sv */
// Back end: framebuffer memory, blend datapath and the output register.
// Depends on sabc_pkg; takes commands from sabc_queue.
`timescale 1ns / 1ps

module sabc_back #(
  parameter int unsigned AW = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           pop_valid_i,
  output logic           pop_ready_o,
  input  sabc_pkg::cmd_t pop_cmd_i,
  input  logic [AW-1:0]  pop_addr_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output sabc_pkg::out_t out_data_o
);

  function automatic logic [16:0] mix_sum(input logic [7:0] s, input logic [7:0] b,
                                          input logic [7:0] a);
    logic [15:0] ps, pb;
    ps = s * a;
    pb = b * (8'd255 - a);
    return 17'(ps) + 17'(pb) + 17'd127;
  endfunction

  // Exact quotient by 255 for sums below 65280.
  function automatic logic [7:0] div255(input logic [16:0] x);
    logic [16:0] t;
    t = x + 17'(x[16:8]) + 17'd1;
    return t[15:8];
  endfunction

  logic [23:0] frame_q [2**AW];
  logic [23:0] rdata_q;

  sabc_pkg::back_state_e state_q, state_d;
  sabc_pkg::cmd_t        cmd_q;
  logic [AW-1:0]         addr_q;
  logic [16:0]           sum0_q, sum1_q, sum2_q;
  logic                  out_valid_q, out_valid_d;
  sabc_pkg::out_t        out_data_q;

  logic           out_free, take, rd_en, wr_en, load;
  logic [AW-1:0]  wr_addr;
  logic [23:0]    wr_data, blended;
  sabc_pkg::out_t res;

  assign out_free = !out_valid_q || !out_stall_i;
  assign blended  = {div255(sum2_q), div255(sum1_q), div255(sum0_q)};

  always_comb begin
    state_d     = state_q;
    pop_ready_o = 1'b0;
    take        = 1'b0;
    rd_en       = 1'b0;
    wr_en       = 1'b0;
    wr_addr     = pop_addr_i;
    wr_data     = pop_cmd_i.pixel;
    load        = 1'b0;
    res         = '0;
    unique case (state_q)
      sabc_pkg::BS_IDLE: begin
        if (pop_valid_i) begin
          unique case (pop_cmd_i.kind) inside
            sabc_pkg::K_READ, sabc_pkg::K_BLEND: begin
              pop_ready_o = 1'b1;
              take        = 1'b1;
              rd_en       = 1'b1;
              state_d     = sabc_pkg::BS_FETCH;
            end
            sabc_pkg::K_WRITE: begin
              if (out_free) begin
                pop_ready_o = 1'b1;
                wr_en       = 1'b1;
                load        = 1'b1;
                res.status  = sabc_pkg::ST_STORED;
              end
            end
            default: begin
              if (out_free) begin
                pop_ready_o = 1'b1;
                load        = 1'b1;
                res.status  = pop_cmd_i.status;
              end
            end
          endcase
        end
      end
      sabc_pkg::BS_FETCH: begin
        if (cmd_q.kind == sabc_pkg::K_READ) begin
          if (out_free) begin
            load           = 1'b1;
            res.status     = sabc_pkg::ST_READ;
            res.out_first  = rdata_q[7:0];
            res.out_second = rdata_q[15:8];
            res.out_third  = rdata_q[23:16];
            state_d        = sabc_pkg::BS_IDLE;
          end
        end else begin
          state_d = sabc_pkg::BS_MIX;
        end
      end
      sabc_pkg::BS_MIX: begin
        if (out_free) begin
          wr_en      = 1'b1;
          wr_addr    = addr_q;
          wr_data    = blended;
          load       = 1'b1;
          res.status = sabc_pkg::ST_STORED;
          state_d    = sabc_pkg::BS_IDLE;
        end
      end
      default: state_d = sabc_pkg::BS_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sabc_pkg::BS_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q  <= pop_cmd_i;
      addr_q <= pop_addr_i;
    end
    if (state_q == sabc_pkg::BS_FETCH) begin
      sum0_q <= mix_sum(cmd_q.pixel[7:0], rdata_q[7:0], cmd_q.alpha);
      sum1_q <= mix_sum(cmd_q.pixel[15:8], rdata_q[15:8], cmd_q.alpha);
      sum2_q <= mix_sum(cmd_q.pixel[23:16], rdata_q[23:16], cmd_q.alpha);
    end
    if (load) begin
      out_data_q <= res;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      frame_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= frame_q[pop_addr_i];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

/* tb/testbench.sv */
// Self-checking testbench for the sprite alpha-blend compositor: directed corner words,
// then phases of random write, blend and read words under several sprite placements.
// Depends on sabc_pkg and the sprite_alpha_blend_compositor top level.
`timescale 1ns / 1ps

module testbench;

  localparam int unsigned FRAME_DIM = 256;
  localparam int unsigned SPRITE_DIM = 64;
  localparam int unsigned OPAQUE = 255;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [sabc_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [sabc_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam int QUIET_LIMIT = 3000;
  localparam int LONG_HOLD = 400;
  localparam int MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  sabc_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  sabc_pkg::out_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [sabc_pkg::CfgIdxW-1:0] cfg_index = '0;
  logic [sabc_pkg::OffW-1:0] cfg_data = '0;

  sabc_pkg::in_t pending_ops[$];
  sabc_pkg::out_t expected_replies[$];
  logic [23:0] fb_model[FRAME_DIM*FRAME_DIM];
  logic signed [sabc_pkg::OffW-1:0] place_row_off = '0;
  logic signed [sabc_pkg::OffW-1:0] place_col_off = '0;

  bit gen_written[FRAME_DIM*FRAME_DIM];
  int gen_row_off;
  int gen_col_off;
  logic [15:0] last_addr;
  logic [7:0] last_sprite_row;
  logic [7:0] last_sprite_col;
  int items_queued = 0;

  bit idle_on = 1'b1;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int send_gap = 0;
  int recv_gap = 0;
  int quiet_cycles = 0;
  int mismatches = 0;

  sprite_alpha_blend_compositor uut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data),
    .cfg_valid_i(cfg_valid),
    .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index),
    .cfg_data_i (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] mix_chan(logic [7:0] spr, logic [7:0] back, logic [7:0] a);
    int unsigned acc;
    acc = int'(spr) * int'(a) + int'(back) * (OPAQUE - int'(a)) + 127;
    return 8'(acc / OPAQUE);
  endfunction

  function automatic sabc_pkg::out_t composite_predict(sabc_pkg::in_t w);
    sabc_pkg::out_t res;
    logic [23:0] px;
    int tr;
    int tc;
    res = '0;
    res.status = sabc_pkg::ST_SKIPPED;
    case (w.op)
      sabc_pkg::OP_WRITE: begin
        fb_model[{w.row, w.col}] = {w.chan_third, w.chan_second, w.chan_first};
        res.status = sabc_pkg::ST_STORED;
      end
      sabc_pkg::OP_READ: begin
        px = fb_model[{w.row, w.col}];
        res.status = sabc_pkg::ST_READ;
        res.out_first = px[7:0];
        res.out_second = px[15:8];
        res.out_third = px[23:16];
      end
      sabc_pkg::OP_BLEND: begin
        if (w.alpha != 8'd0) begin
          tr = int'(w.row) + int'(place_row_off);
          tc = int'(w.col) + int'(place_col_off);
          if (w.row >= SPRITE_DIM || w.col >= SPRITE_DIM || tr < 0 || tc < 0 ||
              tr >= int'(FRAME_DIM) || tc >= int'(FRAME_DIM)) begin
            res.status = sabc_pkg::ST_CLIPPED;
          end else begin
            px = fb_model[{tr[7:0], tc[7:0]}];
            fb_model[{tr[7:0], tc[7:0]}] = {mix_chan(w.chan_third, px[23:16], w.alpha),
                                            mix_chan(w.chan_second, px[15:8], w.alpha),
                                            mix_chan(w.chan_first, px[7:0], w.alpha)};
            res.status = sabc_pkg::ST_STORED;
          end
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk) begin
    if (in_valid && !in_stall) begin
      expected_replies.insert(expected_replies.size(), composite_predict(in_data));
    end
    if (!in_valid || !in_stall) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        send_gap <= $urandom_range(0, 18);
        in_valid <= 1'b0;
      end else if (pending_ops.size() != 0) begin
        in_valid <= 1'b1;
        in_data <= pending_ops.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    sabc_pkg::out_t want;
    if (out_valid && !out_stall) begin
      if (expected_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("Unexpected result word: status %0d channels %h %h %h", out_data.status,
                   out_data.out_first, out_data.out_second, out_data.out_third);
        end
      end else begin
        want = expected_replies.pop_front();
        if (out_data.status !== want.status || out_data.out_first !== want.out_first ||
            out_data.out_second !== want.out_second ||
            out_data.out_third !== want.out_third) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("Result mismatch: expected status %0d channels %h %h %h, got %0d %h %h %h",
                     want.status, want.out_first, want.out_second, want.out_third,
                     out_data.status, out_data.out_first, out_data.out_second,
                     out_data.out_third);
          end
        end
      end
    end
    if (hold_ack != hold_req) begin
      hold_ack <= hold_req;
      hold_left <= LONG_HOLD;
      out_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (recv_gap != 0) begin
      recv_gap <= recv_gap - 1;
      out_stall <= 1'b1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      recv_gap <= $urandom_range(0, 18);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("sprite_alpha_blend_compositor test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic [sabc_pkg::CfgIdxW-1:0] idx,
                           input logic [sabc_pkg::OffW-1:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == sabc_pkg::CFG_ROW_OFFSET) begin
      place_row_off = val;
    end else if (idx == sabc_pkg::CFG_COL_OFFSET) begin
      place_col_off = val;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_ops.size() != 0 || in_valid || expected_replies.size() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic set_placement(input int row_off, input int col_off);
    logic [sabc_pkg::OffW-1:0] rv;
    logic [sabc_pkg::OffW-1:0] cv;
    rv = row_off[sabc_pkg::OffW-1:0];
    cv = col_off[sabc_pkg::OffW-1:0];
    wait_drained();
    repeat (4) @(posedge clk);
    cfg_write(sabc_pkg::CFG_ROW_OFFSET, rv);
    cfg_write(sabc_pkg::CFG_COL_OFFSET, cv);
    gen_row_off = row_off;
    gen_col_off = col_off;
    @(negedge clk);
  endtask

  task automatic push_op(input logic [1:0] op, input logic [7:0] r, input logic [7:0] c,
                         input logic [7:0] c0, input logic [7:0] c1, input logic [7:0] c2,
                         input logic [7:0] a);
    sabc_pkg::in_t w;
    w.op = op;
    w.row = r;
    w.col = c;
    w.chan_first = c0;
    w.chan_second = c1;
    w.chan_third = c2;
    w.alpha = a;
    if (op == sabc_pkg::OP_WRITE) begin
      gen_written[{r, c}] = 1'b1;
      last_addr = {r, c};
    end
    pending_ops.insert(pending_ops.size(), w);
    items_queued++;
  endtask

  task automatic fill_if_blank(input logic [7:0] r, input logic [7:0] c);
    if (!gen_written[{r, c}]) begin
      push_op(sabc_pkg::OP_WRITE, r, c, 8'($urandom), 8'($urandom), 8'($urandom),
              8'($urandom));
    end
  endtask

  task automatic queue_read(input logic [7:0] r, input logic [7:0] c);
    fill_if_blank(r, c);
    push_op(sabc_pkg::OP_READ, r, c, 8'($urandom), 8'($urandom), 8'($urandom),
            8'($urandom));
  endtask

  task automatic queue_blend(input logic [7:0] r, input logic [7:0] c, input logic [7:0] c0,
                             input logic [7:0] c1, input logic [7:0] c2, input logic [7:0] a);
    int tr;
    int tc;
    tr = int'(r) + gen_row_off;
    tc = int'(c) + gen_col_off;
    if (a != 8'd0 && r < SPRITE_DIM && c < SPRITE_DIM && tr >= 0 && tc >= 0 &&
        tr < int'(FRAME_DIM) && tc < int'(FRAME_DIM)) begin
      fill_if_blank(tr[7:0], tc[7:0]);
      last_addr = {tr[7:0], tc[7:0]};
    end
    last_sprite_row = r;
    last_sprite_col = c;
    push_op(sabc_pkg::OP_BLEND, r, c, c0, c1, c2, a);
  endtask

  function automatic logic [7:0] pick_alpha();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd1;
      3: return 8'd254;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic gen_random_ops(input int count);
    int first;
    int pick;
    first = items_queued;
    while (items_queued - first < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 35) begin
        queue_blend(8'($urandom_range(0, SPRITE_DIM - 1)), 8'($urandom_range(0, SPRITE_DIM - 1)),
                    8'($urandom), 8'($urandom), 8'($urandom), pick_alpha());
      end else if (pick < 42) begin
        queue_blend(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    pick_alpha());
      end else if (pick < 52) begin
        queue_blend(last_sprite_row, last_sprite_col, 8'($urandom), 8'($urandom),
                    8'($urandom), pick_alpha());
      end else if (pick < 67) begin
        push_op(sabc_pkg::OP_WRITE, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
      end else if (pick < 80) begin
        queue_read(last_addr[15:8], last_addr[7:0]);
      end else if (pick < 96) begin
        queue_read(8'($urandom), 8'($urandom));
      end else begin
        push_op(OP_UNUSED, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                8'($urandom), 8'($urandom));
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    set_placement(0, 0);
    push_op(sabc_pkg::OP_WRITE, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00);
    push_op(sabc_pkg::OP_WRITE, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    push_op(sabc_pkg::OP_WRITE, 8'h00, 8'hFF, 8'h12, 8'h34, 8'h56, 8'h80);
    push_op(sabc_pkg::OP_WRITE, 8'hFF, 8'h00, 8'hA5, 8'h5A, 8'hC3, 8'h01);
    queue_read(8'hFF, 8'hFF);
    queue_read(8'h00, 8'hFF);
    queue_read(8'hFF, 8'h00);
    queue_blend(8'd0, 8'd0, 8'hFF, 8'h80, 8'h01, 8'd255);
    queue_blend(8'd0, 8'd0, 8'h00, 8'hFF, 8'h7F, 8'd1);
    queue_blend(8'd0, 8'd0, 8'hFF, 8'hFF, 8'h00, 8'd128);
    queue_read(8'd0, 8'd0);
    queue_blend(8'd63, 8'd63, 8'h40, 8'hC0, 8'hFF, 8'd200);
    queue_read(8'd63, 8'd63);
    queue_blend(8'd10, 8'd10, 8'hFF, 8'hFF, 8'hFF, 8'd0);
    queue_blend(8'd64, 8'd5, 8'h11, 8'h22, 8'h33, 8'd9);
    queue_blend(8'd5, 8'd64, 8'h11, 8'h22, 8'h33, 8'd9);
    queue_blend(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'd255);
    push_op(OP_UNUSED, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
    queue_read(8'd0, 8'd0);

    wait_drained();
    cfg_write(CFG_SPARE_A, 10'h3FF);
    cfg_write(CFG_SPARE_B, 10'h155);
    set_placement(-512, 511);
    gen_random_ops(40);
    set_placement(511, -512);
    gen_random_ops(40);
    set_placement(192, 192);
    gen_random_ops(220);
    set_placement(-32, 200);
    gen_random_ops(220);
    hold_req++;
    repeat (3) begin
      set_placement(int'($urandom_range(0, 320)) - 70, int'($urandom_range(0, 320)) - 70);
      gen_random_ops(310);
    end
    set_placement(0, 0);
    idle_on = 1'b0;
    gen_random_ops(220);

    wait_drained();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_replies.size() == 0) begin
      $display("sprite_alpha_blend_compositor test passed");
    end else begin
      $display("sprite_alpha_blend_compositor test failed");
    end
    $finish;
  end

endmodule
